// File: design/stmf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding trimmed mean filter package
// Shared payload types, controller states, command and status bundles and
// default constants for the sliding trimmed mean filter.
// ----------------------------------------------------------------------------
package stmf_pkg;

    // Field widths fixed by the interface.
    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int AGE_W    = 16;

    // Default filter geometry.
    localparam int WINDOW_DEF    = 16;
    localparam int LOW_TRIM_DEF  = 4;
    localparam int HIGH_TRIM_DEF = 4;

    // Reset value of the invalidation limit, in seconds.
    localparam logic [AGE_W-1:0] CFG_RESET = 16'd10;

    // Request codes carried in req_type.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TICK   = 1'b1;

    // Input transaction payload.
    typedef struct packed {
        logic                       req_type;
        logic signed [SAMPLE_W-1:0] sample;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] mean_value;
        logic                       result_valid;
        logic [COUNT_W-1:0]         count_used;
    } t_out_item;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_RANK,
        S_DRAIN,
        S_ABS,
        S_MUL,
        S_FIX,
        S_RND,
        S_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic rank_start;
        logic rank_step;
        logic abs_en;
        logic mul_en;
        logic fix_en;
        logic rnd_en;
        logic finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_rank;
        logic step_last;
        logic pipe_busy;
    } t_status;

endpackage

// File: design/sliding_trimmed_mean_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding trimmed mean filter
// Circular window of signed Q8.8 samples with a trimmed mean output, a
// staleness age counter advanced by tick transactions and one register for
// the invalidation limit.
//
//   Channel  Direction  Handshake                 Payload
//   in       input      i_in_valid / o_in_ready   i_in_data   (t_in_item)
//   out      output     o_out_valid / i_out_ready o_out_data  (t_out_item)
//   cfg      input      i_cfg_we                  i_cfg_wdata (16 bit)
//
// A tick, or a sample while the window is still filling, skips ranking and division.
// A sample into a full window is ranked, drained and then divided:
// ranking compares one candidate against the whole window per cycle.
// Reset is synchronous; no clearing pass follows it.
// Each input transaction yields one output transaction. The block returns to
// idle while a result waits in the output register and stalls only when a
// second result is ready before the first has been taken.
// ----------------------------------------------------------------------------
module sliding_trimmed_mean_filter_top #(
    parameter int WINDOW    = stmf_pkg::WINDOW_DEF,
    parameter int LOW_TRIM  = stmf_pkg::LOW_TRIM_DEF,
    parameter int HIGH_TRIM = stmf_pkg::HIGH_TRIM_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  stmf_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output stmf_pkg::t_out_item         o_out_data,
    input  logic                        i_cfg_we,
    input  logic [stmf_pkg::AGE_W-1:0]  i_cfg_wdata
);

    stmf_pkg::t_cmd    cmd;
    stmf_pkg::t_status status;

    // Sequencer.
    stmf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // Window, ranking, division and filter state.
    stmf_dp #(
        .WINDOW    (WINDOW),
        .LOW_TRIM  (LOW_TRIM),
        .HIGH_TRIM (HIGH_TRIM)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (o_out_data)
    );

endmodule

// File: design/stmf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding trimmed mean filter controller
// Sequences one transaction at a time through ranking, division and the
// final state update, and owns the output valid flag.
// ----------------------------------------------------------------------------
module stmf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  stmf_pkg::t_status i_status,
    output stmf_pkg::t_cmd    o_cmd
);

    stmf_pkg::t_state r_state;
    stmf_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= stmf_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state logic.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stmf_pkg::S_IDLE: begin
                if (i_in_valid) n_state = stmf_pkg::S_CHECK;
            end
            stmf_pkg::S_CHECK: begin
                n_state = i_status.need_rank ? stmf_pkg::S_RANK : stmf_pkg::S_FINISH;
            end
            stmf_pkg::S_RANK: begin
                if (i_status.step_last) n_state = stmf_pkg::S_DRAIN;
            end
            stmf_pkg::S_DRAIN: begin
                if (!i_status.pipe_busy) n_state = stmf_pkg::S_ABS;
            end
            stmf_pkg::S_ABS: begin
                n_state = stmf_pkg::S_MUL;
            end
            stmf_pkg::S_MUL: begin
                n_state = stmf_pkg::S_FIX;
            end
            stmf_pkg::S_FIX: begin
                n_state = stmf_pkg::S_RND;
            end
            stmf_pkg::S_RND: begin
                n_state = stmf_pkg::S_FINISH;
            end
            stmf_pkg::S_FINISH: begin
                if (!r_out_valid || i_out_ready) n_state = stmf_pkg::S_IDLE;
            end
            default: begin
                n_state = stmf_pkg::S_IDLE;
            end
        endcase
    end

    // Command outputs.
    always_comb begin
        o_cmd = '0;
        unique case (r_state)
            stmf_pkg::S_IDLE:   o_cmd.accept     = i_in_valid;
            stmf_pkg::S_CHECK:  o_cmd.rank_start = i_status.need_rank;
            stmf_pkg::S_RANK:   o_cmd.rank_step  = 1'b1;
            stmf_pkg::S_DRAIN:  o_cmd            = '0;
            stmf_pkg::S_ABS:    o_cmd.abs_en     = 1'b1;
            stmf_pkg::S_MUL:    o_cmd.mul_en     = 1'b1;
            stmf_pkg::S_FIX:    o_cmd.fix_en     = 1'b1;
            stmf_pkg::S_RND:    o_cmd.rnd_en     = 1'b1;
            stmf_pkg::S_FINISH: o_cmd.finish     = !r_out_valid || i_out_ready;
            default:            o_cmd            = '0;
        endcase
    end

    // The output register is full from a finish until its transaction is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == stmf_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    // An accepted transaction always moves on to the decision state.
    a_accept_to_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == stmf_pkg::S_CHECK))
        else $error("accepted transaction did not reach the check state");

    // A finished result waits while the previous one is still held.
    a_finish_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stmf_pkg::S_FINISH && r_out_valid && !i_out_ready)
        |=> (r_state == stmf_pkg::S_FINISH && r_out_valid))
        else $error("finish did not wait for the output register");

    // The ranking pass ends on the last step.
    a_rank_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == stmf_pkg::S_RANK && i_status.step_last)
        |=> (r_state == stmf_pkg::S_DRAIN))
        else $error("ranking pass did not end on its last step");
`endif

endmodule

// File: design/stmf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding trimmed mean filter datapath
// Holds the sample window, ranks each entry against the whole window one
// candidate per cycle, sums the kept entries, divides by the kept count and
// keeps the validity and age state.
// ----------------------------------------------------------------------------
module stmf_dp #(
    parameter int WINDOW    = stmf_pkg::WINDOW_DEF,
    parameter int LOW_TRIM  = stmf_pkg::LOW_TRIM_DEF,
    parameter int HIGH_TRIM = stmf_pkg::HIGH_TRIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  stmf_pkg::t_in_item               i_in_data,
    input  logic                             i_cfg_we,
    input  logic [stmf_pkg::AGE_W-1:0]       i_cfg_wdata,
    input  stmf_pkg::t_cmd                   i_cmd,
    output stmf_pkg::t_status                o_status,
    output stmf_pkg::t_out_item              o_out_data
);

    localparam int SW      = stmf_pkg::SAMPLE_W;
    localparam int IDX_W   = $clog2(WINDOW);
    localparam int FILL_W  = $clog2(WINDOW + 1);
    localparam int RANK_W  = FILL_W;
    localparam int SUM_W   = SW + 1 + $clog2(WINDOW);
    localparam int CNT     = WINDOW - LOW_TRIM - HIGH_TRIM;
    localparam int CNT_D   = (CNT > 0) ? CNT : 1;
    localparam bit HAS_AVG = (CNT > 0);
    localparam int RECIP_W = SUM_W + 1;
    localparam int PROD_W  = SUM_W + RECIP_W;
    // Reciprocal of the kept count, scaled by 2**SUM_W and rounded down.
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((2 ** SUM_W) / CNT_D);
    localparam logic [stmf_pkg::COUNT_W-1:0] COUNT =
        HAS_AVG ? stmf_pkg::COUNT_W'(CNT) : '0;

    logic signed [SW-1:0]              r_win [WINDOW];
    logic [FILL_W-1:0]                 r_fill;
    logic                              r_is_tick;
    logic [IDX_W-1:0]                  r_step;
    logic                              step_last;
    logic                              r_v1;
    logic                              r_v2;
    logic [WINDOW-1:0]                 n_vec;
    logic [WINDOW-1:0]                 r_vec;
    logic signed [SW-1:0]              r_cand1;
    logic signed [SW-1:0]              r_cand2;
    logic [RANK_W-1:0]                 n_rank;
    logic [RANK_W-1:0]                 r_rank;
    logic                              in_range;
    logic signed [SUM_W-1:0]           r_sum;
    logic                              r_neg;
    logic [SUM_W-1:0]                  r_mag;
    logic [PROD_W-1:0]                 r_prod;
    logic [SUM_W-1:0]                  n_q0;
    logic [SUM_W-1:0]                  r_q0;
    logic [SUM_W-1:0]                  r_rem;
    logic [SUM_W-1:0]                  n_q;
    logic [SW-1:0]                     n_qs;
    logic signed [SW-1:0]              r_quot;
    logic                              full;
    logic                              r_vflag;
    logic                              n_vflag;
    logic signed [SW-1:0]              r_last_mean;
    logic signed [SW-1:0]              n_last_mean;
    logic [stmf_pkg::AGE_W-1:0]        r_age;
    logic [stmf_pkg::AGE_W-1:0]        n_age;
    logic [stmf_pkg::AGE_W-1:0]        r_cfg;
    stmf_pkg::t_out_item               r_out;

    // Window shift line: samples shift in at the head, ranking rotates it once.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && (i_in_data.req_type == stmf_pkg::REQ_SAMPLE)) begin
            r_win[0] <= i_in_data.sample;
            for (int k = 1; k < WINDOW; k++) begin
                r_win[k] <= r_win[k-1];
            end
        end else if (i_cmd.rank_step) begin
            for (int k = 0; k < WINDOW; k++) begin
                r_win[k] <= r_win[(k + 1) % WINDOW];
            end
        end
    end

    // Fill level and request kind of the transaction in progress.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill    <= '0;
            r_is_tick <= 1'b0;
        end else if (i_cmd.accept) begin
            r_is_tick <= (i_in_data.req_type == stmf_pkg::REQ_TICK);
            if ((i_in_data.req_type == stmf_pkg::REQ_SAMPLE)
                && (r_fill != FILL_W'(WINDOW))) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    assign full = (r_fill == FILL_W'(WINDOW));

    // Ranking step counter; it wraps back to zero after the last candidate.
    assign step_last = (r_step == IDX_W'(WINDOW - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= '0;
        end else if (i_cmd.rank_start) begin
            r_step <= '0;
        end else if (i_cmd.rank_step) begin
            r_step <= step_last ? '0 : r_step + 1'b1;
        end
    end

    // Stage 1: compare every entry with the candidate at the head. Equal
    // entries that came earlier in the original order count as smaller, so
    // every entry gets a distinct rank.
    always_comb begin
        for (int p = 0; p < WINDOW; p++) begin
            n_vec[p] = (r_win[p] < r_win[0])
                || ((r_win[p] == r_win[0])
                    && (({1'b0, r_step} + (IDX_W + 1)'(p)) >= (IDX_W + 1)'(WINDOW)));
        end
    end

    // Stage 2: the rank is the number of entries ahead of the candidate.
    always_comb begin
        n_rank = '0;
        for (int p = 0; p < WINDOW; p++) begin
            n_rank = n_rank + RANK_W'(r_vec[p]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rank_step;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_vec   <= n_vec;
        r_cand1 <= r_win[0];
        r_rank  <= n_rank;
        r_cand2 <= r_cand1;
    end

    // Stage 3: add the candidate when its rank falls inside the kept range.
    assign in_range = (int'(r_rank) >= LOW_TRIM) && (int'(r_rank) < (WINDOW - HIGH_TRIM));

    always_ff @(posedge i_clk) begin
        if (i_cmd.rank_start) begin
            r_sum <= '0;
        end else if (r_v2 && in_range) begin
            r_sum <= r_sum + SUM_W'(r_cand2);
        end
    end

    // Division by the kept count: magnitude, reciprocal multiply, remainder
    // check with one correction, then the sign restored (truncation to zero).
    always_comb begin
        n_q0 = r_prod[SUM_W +: SUM_W];
        n_q  = (r_rem >= SUM_W'(CNT_D)) ? r_q0 + 1'b1 : r_q0;
        n_qs = n_q[SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.abs_en) begin
            r_neg <= r_sum[SUM_W-1];
            r_mag <= r_sum[SUM_W-1] ? unsigned'(-r_sum) : unsigned'(r_sum);
        end
        if (i_cmd.mul_en) begin
            r_prod <= PROD_W'(r_mag) * PROD_W'(RECIP);
        end
        if (i_cmd.fix_en) begin
            r_q0  <= n_q0;
            r_rem <= r_mag - SUM_W'(n_q0 * SUM_W'(CNT_D));
        end
        if (i_cmd.rnd_en) begin
            r_quot <= r_neg ? signed'(SW'(-n_qs)) : signed'(n_qs);
        end
    end

    // Filter state after the transaction, staleness check last.
    always_comb begin
        n_vflag     = r_vflag;
        n_last_mean = r_last_mean;
        n_age       = r_age;
        if (r_is_tick) begin
            if (r_age != '1) n_age = r_age + 1'b1;
        end else if (!full || !HAS_AVG) begin
            n_vflag     = 1'b0;
            n_last_mean = '0;
        end else begin
            n_vflag     = 1'b1;
            n_last_mean = r_quot;
            n_age       = '0;
        end
        if (n_age > r_cfg) begin
            n_vflag     = 1'b0;
            n_last_mean = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vflag     <= 1'b0;
            r_last_mean <= '0;
            r_age       <= '0;
        end else if (i_cmd.finish) begin
            r_vflag     <= n_vflag;
            r_last_mean <= n_last_mean;
            r_age       <= n_age;
        end
    end

    // Invalidation limit register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= stmf_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out.mean_value   <= n_vflag ? n_last_mean : '0;
            r_out.result_valid <= n_vflag;
            r_out.count_used   <= n_vflag ? COUNT : '0;
        end
    end

    assign o_out_data         = r_out;
    assign o_status.need_rank = !r_is_tick && full && HAS_AVG;
    assign o_status.step_last = step_last;
    assign o_status.pipe_busy = r_v1 || r_v2;

`ifndef SYNTHESIS
    // Division starts only once the rank pipeline has emptied and the
    // step counter has wrapped back.
    a_div_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.abs_en |-> (!r_v1 && !r_v2 && (r_step == '0)))
        else $error("division started before the rank pipeline drained");

    // The held mean is cleared whenever the result is not valid.
    a_mean_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vflag |-> (r_last_mean == '0))
        else $error("held mean is nonzero while the result is invalid");

    // A finished transaction reports the flag that the state update produced.
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.finish |=> (r_out.result_valid == r_vflag))
        else $error("output valid flag disagrees with filter state");
`endif

endmodule
